// ===== src/video_syntax_bitstream_reader_assert.svh =====
// Assertion macros used by the checker file.
`ifndef VIDEO_SYNTAX_BITSTREAM_READER_ASSERT_SVH
`define VIDEO_SYNTAX_BITSTREAM_READER_ASSERT_SVH
`define VSBR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define VSBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/vsbr_pkg.sv =====
// Shared types and constants of the bitstream reader.
package vsbr_pkg;
   localparam int STORE_BYTES = 16;
   localparam int MAX_LEADING_ZEROS = 31;
   localparam int AW = $clog2(STORE_BYTES);
   localparam int FW = $clog2(STORE_BYTES + 1);

   localparam logic [2:0] FN_PUSH  = 3'd0;
   localparam logic [2:0] FN_FIXED = 3'd1;
   localparam logic [2:0] FN_UE    = 3'd2;
   localparam logic [2:0] FN_SE    = 3'd3;
   localparam logic [2:0] FN_ME    = 3'd4;
   localparam logic [2:0] FN_TE    = 3'd5;
   localparam logic [2:0] FN_ALIGN = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_CODE  = 2'd3;

   typedef struct packed {
      logic       start;
      logic       take_bit;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic       have_bit;
      logic       bit_val;
      logic       cur_aligned;
   } sts_type;

   function automatic logic [5:0] me_mid(input logic [5:0] k, input logic c);
      logic [11:0] e;
      unique case (k)
         6'd0: e = {6'd47, 6'd0};   6'd1: e = {6'd31, 6'd16};
         6'd2: e = {6'd15, 6'd1};   6'd3: e = {6'd0, 6'd2};
         6'd4: e = {6'd23, 6'd4};   6'd5: e = {6'd27, 6'd8};
         6'd6: e = {6'd29, 6'd32};  6'd7: e = {6'd30, 6'd3};
         6'd8: e = {6'd7, 6'd5};    6'd9: e = {6'd11, 6'd10};
         6'd10: e = {6'd13, 6'd12}; 6'd11: e = {6'd14, 6'd15};
         6'd12: e = {6'd39, 6'd47}; 6'd13: e = {6'd43, 6'd7};
         6'd14: e = {6'd45, 6'd11}; 6'd15: e = {6'd46, 6'd13};
         6'd16: e = {6'd16, 6'd14}; 6'd17: e = {6'd3, 6'd6};
         6'd18: e = {6'd5, 6'd9};   6'd19: e = {6'd10, 6'd31};
         6'd20: e = {6'd12, 6'd35}; 6'd21: e = {6'd19, 6'd37};
         6'd22: e = {6'd21, 6'd42}; 6'd23: e = {6'd26, 6'd44};
         6'd24: e = {6'd28, 6'd33}; 6'd25: e = {6'd35, 6'd34};
         6'd26: e = {6'd37, 6'd36}; 6'd27: e = {6'd42, 6'd40};
         6'd28: e = {6'd44, 6'd39}; 6'd29: e = {6'd1, 6'd43};
         6'd30: e = {6'd2, 6'd45};  6'd31: e = {6'd4, 6'd46};
         6'd32: e = {6'd8, 6'd17};  6'd33: e = {6'd17, 6'd18};
         6'd34: e = {6'd18, 6'd20}; 6'd35: e = {6'd20, 6'd24};
         6'd36: e = {6'd24, 6'd19}; 6'd37: e = {6'd6, 6'd21};
         6'd38: e = {6'd9, 6'd26};  6'd39: e = {6'd22, 6'd28};
         6'd40: e = {6'd25, 6'd23}; 6'd41: e = {6'd32, 6'd27};
         6'd42: e = {6'd33, 6'd29}; 6'd43: e = {6'd34, 6'd30};
         6'd44: e = {6'd36, 6'd22}; 6'd45: e = {6'd40, 6'd25};
         6'd46: e = {6'd38, 6'd38}; 6'd47: e = {6'd41, 6'd41};
         default: e = '0;
      endcase
      return c ? e[5:0] : e[11:6];
   endfunction

   function automatic logic [5:0] me_full(input logic [3:0] k, input logic c);
      logic [7:0] e;
      unique case (k)
         4'd0: e = {4'd15, 4'd0};  4'd1: e = {4'd0, 4'd1};
         4'd2: e = {4'd7, 4'd2};   4'd3: e = {4'd11, 4'd4};
         4'd4: e = {4'd13, 4'd8};  4'd5: e = {4'd14, 4'd3};
         4'd6: e = {4'd3, 4'd5};   4'd7: e = {4'd5, 4'd10};
         4'd8: e = {4'd10, 4'd12}; 4'd9: e = {4'd12, 4'd15};
         4'd10: e = {4'd1, 4'd7};  4'd11: e = {4'd2, 4'd11};
         4'd12: e = {4'd4, 4'd13}; 4'd13: e = {4'd8, 4'd14};
         4'd14: e = {4'd6, 4'd6};  default: e = {4'd9, 4'd9};
      endcase
      return {2'b00, c ? e[3:0] : e[7:4]};
   endfunction
endpackage

// ===== src/vsbr_ram.sv =====
// Generic single-port-write RAM with registered read.
module vsbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/vsbr_datapath.sv =====
// Byte store, cursor and bit extraction datapath.
module vsbr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  logic [7:0]          push_byte,
   input  logic                commit,
   input  logic                align_en,
   input  vsbr_pkg::cmd_type   cmd,
   output vsbr_pkg::sts_type   sts,
   output logic [vsbr_pkg::FW-1:0] fill,
   output logic                aligned
);
   import vsbr_pkg::*;
   logic [AW-1:0] rslot_ff, rslot_in, wslot_ff, cslot_ff, cslot_in;
   logic [FW-1:0] fill_ff, fill_in, cfill_ff, cfill_in;
   logic [2:0]    off_ff, off_in, coff_ff, coff_in;
   logic [7:0]    rd_data;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
      return (s == AW'(STORE_BYTES - 1)) ? '0 : s + 1'b1;
   endfunction

   vsbr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
      .clock(clock), .wr_en(push_en), .wr_addr(wslot_ff), .wr_data(push_byte),
      .rd_addr(cslot_in), .rd_data(rd_data));

   assign sts.have_bit = (cfill_ff != '0);
   assign sts.bit_val  = rd_data[3'd7 - coff_ff];
   assign sts.cur_aligned = (coff_ff == 3'd0);
   assign fill = fill_ff;
   assign aligned = (off_ff == 3'd0);

   always_comb begin
      cslot_in = cslot_ff; coff_in = coff_ff; cfill_in = cfill_ff;
      rslot_in = rslot_ff; off_in = off_ff; fill_in = fill_ff;
      if (cmd.start) begin
         cslot_in = rslot_ff; coff_in = off_ff; cfill_in = fill_ff;
      end else if (cmd.take_bit) begin
         coff_in = coff_ff + 3'd1;
         if (coff_ff == 3'd7) begin
            cslot_in = next_slot(cslot_ff);
            cfill_in = cfill_ff - 1'b1;
         end
      end
      if (commit) begin
         rslot_in = cslot_ff; off_in = coff_ff; fill_in = cfill_ff;
      end else if (align_en && off_ff != 3'd0 && fill_ff != '0) begin
         rslot_in = next_slot(rslot_ff); off_in = 3'd0; fill_in = fill_ff - 1'b1;
      end
      if (push_en) begin
         fill_in = fill_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rslot_ff <= '0; wslot_ff <= '0; fill_ff <= '0; off_ff <= '0;
         cslot_ff <= '0; coff_ff <= '0; cfill_ff <= '0;
      end else begin
         rslot_ff <= rslot_in; fill_ff <= fill_in; off_ff <= off_in;
         cslot_ff <= cslot_in; coff_ff <= coff_in; cfill_ff <= cfill_in;
         if (push_en) begin
            wslot_ff <= next_slot(wslot_ff);
         end
      end
   end
endmodule

// ===== src/vsbr_control.sv =====
// Sequencer for push, fixed, Exp-Golomb and align requests.
module vsbr_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_func,
   input  logic [7:0]          req_data_byte,
   input  logic [6:0]          req_bit_count,
   input  logic                req_inter_column,
   input  logic [7:0]          req_te_range,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [63:0]         rsp_value,
   output logic [1:0]          rsp_status,
   output logic                rsp_byte_aligned,
   input  logic [1:0]          chroma,
   output logic                push_en,
   output logic [7:0]          push_byte,
   output logic                commit,
   output logic                align_en,
   output vsbr_pkg::cmd_type   cmd,
   input  vsbr_pkg::sts_type   sts,
   input  logic [vsbr_pkg::FW-1:0] fill,
   input  logic                aligned
);
   import vsbr_pkg::*;
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_LOAD = 6'b000010, S_ZERO = 6'b000100,
      S_SUFF = 6'b001000, S_DONE = 6'b010000, S_RESP = 6'b100000
   } state_type;
   state_type state_ff, state_in;
   logic [2:0]  func_ff;
   logic [7:0]  byte_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic [5:0]  zeros_ff, zeros_in;
   logic [63:0] acc_ff, acc_in, val_ff, val_in;
   logic [1:0]  st_ff, st_in;
   logic        col_ff, fixed_ff, fixed_in;
   logic [1:0]  zrun_ff, zrun_in;
   logic        held_ff, held_in;
   logic        alg_ff, alg_in;
   logic [63:0] k;
   logic [FW:0] freeb;
   logic        acc_bit;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_value = val_ff;
   assign rsp_status = st_ff;
   assign rsp_byte_aligned = alg_ff;
   assign freeb = (FW+1)'(STORE_BYTES) - {1'b0, fill};
   assign k = acc_ff - 64'd1;
   assign acc_bit = sts.bit_val;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; zeros_in = zeros_ff;
      acc_in = acc_ff; val_in = val_ff; st_in = st_ff; fixed_in = fixed_ff;
      zrun_in = zrun_ff; held_in = held_ff; alg_in = alg_ff;
      push_en = 1'b0; push_byte = req_data_byte; commit = 1'b0; align_en = 1'b0;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in = '0; st_in = ST_OK; acc_in = '0; zeros_in = '0;
               cnt_in = (req_bit_count > 7'd64) ? 7'd64 : req_bit_count;
               fixed_in = (req_func == FN_FIXED) ||
                          (req_func == FN_TE && req_te_range <= 8'd1);
               if (req_func == FN_TE && req_te_range <= 8'd1) cnt_in = 7'd1;
               cmd.start = 1'b1;
               state_in = S_RESP;
               unique case (req_func) inside
                  FN_PUSH: begin
                     if (held_ff) begin
                        if (req_data_byte <= 8'd3) begin
                           if (freeb == '0) st_in = ST_FULL;
                           else begin
                              push_en = 1'b1; held_in = 1'b0;
                              zrun_in = (req_data_byte == 8'd0) ? 2'd1 : 2'd0;
                           end
                        end else if (freeb < (FW+1)'(2)) st_in = ST_FULL;
                        else begin
                           push_en = 1'b1; push_byte = 8'd3; held_in = 1'b0;
                           zrun_in = 2'd0; state_in = S_LOAD;
                        end
                     end else if (zrun_ff == 2'd2 && req_data_byte == 8'd3) begin
                        held_in = 1'b1; zrun_in = 2'd0;
                     end else if (freeb == '0) st_in = ST_FULL;
                     else begin
                        push_en = 1'b1;
                        zrun_in = (req_data_byte != 8'd0) ? 2'd0 :
                                  (zrun_ff == 2'd2) ? 2'd2 : zrun_ff + 2'd1;
                     end
                  end
                  FN_FIXED, FN_UE, FN_SE, FN_ME, FN_TE: state_in = S_LOAD;
                  FN_ALIGN: align_en = 1'b1;
                  default: ;
               endcase
            end
            alg_in = (req_func == FN_ALIGN && fill != '0) ? 1'b1 : aligned;
         end
         S_LOAD: begin
            if (func_ff == FN_PUSH) begin
               push_en = 1'b1; push_byte = byte_ff; state_in = S_RESP;
            end else if (fixed_ff) state_in = (cnt_ff == '0) ? S_DONE : S_SUFF;
            else state_in = S_ZERO;
         end
         S_ZERO: begin
            if (!sts.have_bit) begin
               st_in = ST_UNDER; state_in = S_RESP;
            end else begin
               cmd.take_bit = 1'b1;
               if (acc_bit) begin
                  acc_in = 64'd1; cnt_in = {1'b0, zeros_ff};
                  state_in = (zeros_ff == '0) ? S_DONE : S_SUFF;
               end else if (zeros_ff == 6'(MAX_LEADING_ZEROS)) begin
                  st_in = ST_CODE; state_in = S_RESP;
               end else zeros_in = zeros_ff + 6'd1;
            end
         end
         S_SUFF: begin
            if (!sts.have_bit) begin
               st_in = ST_UNDER; state_in = S_RESP;
            end else begin
               cmd.take_bit = 1'b1;
               acc_in = {acc_ff[62:0], acc_bit};
               cnt_in = cnt_ff - 7'd1;
               if (cnt_ff == 7'd1) state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_RESP; commit = 1'b1;
            if (fixed_ff) begin
               val_in = (func_ff == FN_TE) ? {63'd0, ~acc_ff[0]} : acc_ff;
            end else begin
               unique case (func_ff)
                  FN_SE: val_in = k[0] ? ({1'b0, k[63:1]} + 64'd1)
                                       : (64'd0 - {1'b0, k[63:1]});
                  FN_ME: begin
                     if (chroma == 2'd0 || chroma == 2'd3) begin
                        if (k < 64'd16) val_in = {58'd0, me_full(k[3:0], col_ff)};
                        else begin st_in = ST_CODE; commit = 1'b0; end
                     end else begin
                        if (k < 64'd48) val_in = {58'd0, me_mid(k[5:0], col_ff)};
                        else begin st_in = ST_CODE; commit = 1'b0; end
                     end
                  end
                  default: val_in = k;
               endcase
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_IDLE && state_ff != S_RESP && state_in == S_RESP) begin
         alg_in = commit ? sts.cur_aligned : aligned;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; zrun_ff <= '0; held_ff <= 1'b0;
      end else begin
         state_ff <= state_in; zrun_ff <= zrun_in; held_ff <= held_in;
      end
      if (state_ff == S_IDLE) begin
         func_ff <= req_func; byte_ff <= req_data_byte; col_ff <= req_inter_column;
      end
      cnt_ff <= cnt_in; zeros_ff <= zeros_in; acc_ff <= acc_in;
      val_ff <= val_in; st_ff <= st_in; fixed_ff <= fixed_in;
      alg_ff <= alg_in;
   end
endmodule

// ===== src/video_syntax_bitstream_reader.sv =====
// Top level of the video syntax bitstream reader.
// Requests enter on req_valid/req_ready: func 0 pushes one stream byte,
// funcs 1 to 5 read a fixed field, ue, se, me or te code, func 6 aligns.
// A 0x03 after two zero bytes is dropped when the next pushed byte is at most 0x03.
// Each request yields one beat on rsp_valid/rsp_ready with value, status
// and byte_aligned. A push, an align or an unused func goes from S_IDLE
// straight to S_RESP; a push that also stores a held 0x03 passes
// through S_LOAD first. A read passes S_LOAD, then S_ZERO (codes only)
// and S_SUFF, examining n bits for a fixed field, 2z+1 for a code with z
// leading zeros, fewer when a read runs short or hits a code error.
// Bits are taken one per cycle from the registered read port of the byte
// store. A read whose bits all arrive passes S_DONE before S_RESP.
// One request is in flight at a time; req_ready is low until the
// response beat is taken, so a stalled receiver holds the block.
// Reset clears cursors, fill count and the escape tracking; the byte
// store needs no clearing since only written entries are read.
// csr_write_enable with csr_write_data sets chroma_format, reset value 1.
module video_syntax_bitstream_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic [6:0]  req_bit_count,
   input  logic        req_inter_column,
   input  logic [7:0]  req_te_range,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_byte_aligned,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);
   import vsbr_pkg::*;
   logic [1:0] chroma_ff;
   logic push_en, commit, align_en, aligned;
   logic [7:0] push_byte;
   logic [FW-1:0] fill;
   cmd_type cmd;
   sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) chroma_ff <= 2'd1;
      else if (csr_write_enable) chroma_ff <= csr_write_data;
   end

   vsbr_control u_ctrl (.*, .chroma(chroma_ff));
   vsbr_datapath u_dp (.clock, .reset, .push_en, .push_byte, .commit,
      .align_en, .cmd, .sts, .fill, .aligned);
endmodule

// ===== src/vsbr_checker.sv =====
// Port-level checker for the bitstream reader, bound to the top level.
`include "video_syntax_bitstream_reader_assert.svh"
module vsbr_port_checker (
   input logic clock, reset, req_valid, req_ready, rsp_valid, rsp_ready,
   input logic [1:0] rsp_status, input logic [63:0] rsp_value
);
   import vsbr_pkg::*;
   `VSBR_ASSERT_IMPL(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   `VSBR_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_value == '0)
   `VSBR_ASSERT_NEXT(a_rsp_follow, clock, reset, rsp_valid && rsp_ready, req_ready)
   `VSBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))
endmodule
bind video_syntax_bitstream_reader vsbr_port_checker u_chk (.*);
